// ===== hdl/ssid_pkg.sv =====
// Package for the sorted set engine: capacity, widths, codes and cell control.
// No dependencies; used by the interfaces, the cell row, the top level and the checker.
package ssid_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_DUP     = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_e;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic                    cmp;
    logic                    ins;
    logic                    del;
    logic signed [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

// ===== hdl/ssid_ifs.sv =====
// Valid/ready channel interfaces for request and response words.
// Depends on ssid_pkg for field widths.
interface ssid_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       opcode;
  logic signed [ssid_pkg::KEY_W-1:0] key_value;

  modport source (output valid, opcode, key_value, input ready);
  modport sink   (input valid, opcode, key_value, output ready);
endinterface

interface ssid_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [ssid_pkg::CNT_W-1:0] position;
  logic [ssid_pkg::CNT_W-1:0] count;
  logic [1:0]                 status;

  modport source (output valid, found, position, count, status, input ready);
  modport sink   (input valid, found, position, count, status, output ready);
endinterface

// ===== hdl/sorted_set_insert_delete.sv =====
// Top level of the sorted set engine: sequencer, row of cells, response register.
// Depends on ssid_pkg, ssid_req_if, ssid_rsp_if and ssid_cell.
//
//  channel | direction | word                               | handshake
//  req_i   | in        | opcode, key_value                  | valid/ready
//  rsp_o   | out       | found, position, count, status     | valid/ready
//
// Each request passes through three steps: accept, compare in every cell, then shift and
// load the response. The compare cycle is set by the row of cells, all of which
// compare against the broadcast key at once. After reset the set is empty.
// A response waiting on rsp_o does not block the next request; it holds the
// shift step until the waiting word is taken.
module sorted_set_insert_delete (
  input  logic            clk_i,
  input  logic            rst_ni,
  ssid_req_if.sink        req_i,
  ssid_rsp_if.source      rsp_o
);

  localparam int unsigned Cap  = ssid_pkg::CAPACITY;
  localparam int unsigned CntW = ssid_pkg::CNT_W;
  localparam int unsigned KeyW = ssid_pkg::KEY_W;

  ssid_pkg::state_e state_q, state_d;

  logic [1:0]               op_q;
  logic signed [KeyW-1:0]   key_q;
  logic [CntW-1:0]          count_q, count_d;

  logic signed [KeyW-1:0]   entry [Cap];
  logic [Cap-1:0]           lt, eq;
  logic [Cap:0]             bnd;

  ssid_pkg::cell_ctrl_t     ctrl;
  logic                     upd_go;
  logic                     hit;
  logic                     full;
  logic [CntW-1:0]          pos;
  ssid_pkg::status_e        status;

  logic                     rsp_valid_q;
  logic                     rsp_found_q;
  logic [CntW-1:0]          rsp_pos_q, rsp_count_q;
  ssid_pkg::status_e        rsp_status_q;

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ssid_pkg::S_IDLE: if (req_i.valid) state_d = ssid_pkg::S_CMP;
      ssid_pkg::S_CMP:  state_d = ssid_pkg::S_UPD;
      ssid_pkg::S_UPD:  if (upd_go) state_d = ssid_pkg::S_IDLE;
      default:          state_d = ssid_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssid_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      op_q  <= req_i.opcode;
      key_q <= req_i.key_value;
    end
  end

  // Boundary is the first cell whose entry is not below the key.
  always_comb begin
    pos = '0;
    hit = 1'b0;
    for (int i = 0; i <= Cap; i++) begin
      if (i == 0) begin
        bnd[i] = !lt[0];
      end else if (i == Cap) begin
        bnd[i] = lt[Cap-1];
      end else begin
        bnd[i] = lt[i-1] && !lt[i];
      end
    end
    for (int i = 0; i <= Cap; i++) begin
      if (bnd[i]) pos = pos | CntW'(i);
    end
    for (int i = 0; i < Cap; i++) begin
      if (bnd[i] && eq[i]) hit = 1'b1;
    end
  end

  assign full = (count_q == CntW'(Cap));

  always_comb begin
    req_i.ready = (state_q == ssid_pkg::S_IDLE);
    upd_go      = (state_q == ssid_pkg::S_UPD) && (!rsp_valid_q || rsp_o.ready);
    ctrl.cmp    = (state_q == ssid_pkg::S_CMP);
    ctrl.ins    = 1'b0;
    ctrl.del    = 1'b0;
    ctrl.key    = key_q;
    count_d     = count_q;
    case (op_q)
      ssid_pkg::OP_INSERT: begin
        if (hit) begin
          status = ssid_pkg::ST_DUP;
        end else if (full) begin
          status = ssid_pkg::ST_FULL;
        end else begin
          status   = ssid_pkg::ST_DONE;
          ctrl.ins = upd_go;
          count_d  = count_q + CntW'(1);
        end
      end
      ssid_pkg::OP_DELETE: begin
        if (hit) begin
          status   = ssid_pkg::ST_DONE;
          ctrl.del = upd_go;
          count_d  = count_q - CntW'(1);
        end else begin
          status = ssid_pkg::ST_MISSING;
        end
      end
      default: status = hit ? ssid_pkg::ST_DONE : ssid_pkg::ST_MISSING;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (upd_go) begin
      count_q <= count_d;
    end
  end

  // Row of cells
  for (genvar g = 0; g < Cap; g++) begin : g_cell
    logic signed [KeyW-1:0] left_entry, right_entry;
    logic                   left_lt;
    logic                   valid;

    if (g == 0) begin : g_first
      assign left_entry = '0;
      assign left_lt    = 1'b1;
    end else begin : g_mid
      assign left_entry = entry[g-1];
      assign left_lt    = lt[g-1];
    end
    if (g == Cap - 1) begin : g_last
      assign right_entry = entry[g];
    end else begin : g_inner
      assign right_entry = entry[g+1];
    end
    assign valid = (CntW'(g) < count_q);

    ssid_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .valid_i       (valid),
      .left_entry_i  (left_entry),
      .left_lt_i     (left_lt),
      .right_entry_i (right_entry),
      .entry_o       (entry[g]),
      .lt_o          (lt[g]),
      .eq_o          (eq[g])
    );
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (upd_go) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_go) begin
      rsp_found_q  <= hit;
      rsp_pos_q    <= pos;
      rsp_count_q  <= count_d;
      rsp_status_q <= status;
    end
  end

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.found    = rsp_found_q;
  assign rsp_o.position = rsp_pos_q;
  assign rsp_o.count    = rsp_count_q;
  assign rsp_o.status   = rsp_status_q;

endmodule

// ===== hdl/ssid_cell.sv =====
// One storage cell of the sorted row: holds one entry and its compare flags.
// Depends on ssid_pkg; instanced once per entry by the top level.
module ssid_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ssid_pkg::cell_ctrl_t               ctrl_i,
  input  logic                               valid_i,
  input  logic signed [ssid_pkg::KEY_W-1:0]  left_entry_i,
  input  logic                               left_lt_i,
  input  logic signed [ssid_pkg::KEY_W-1:0]  right_entry_i,
  output logic signed [ssid_pkg::KEY_W-1:0]  entry_o,
  output logic                               lt_o,
  output logic                               eq_o
);

  logic signed [ssid_pkg::KEY_W-1:0] entry_q, entry_d;
  logic                              lt_q, eq_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      // Cells above the slot take their left neighbor; the slot takes the key.
      if (!left_lt_i) begin
        entry_d = left_entry_i;
      end else if (!lt_q) begin
        entry_d = ctrl_i.key;
      end
    end else if (ctrl_i.del) begin
      if (!lt_q) begin
        entry_d = right_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctrl_i.cmp) begin
      lt_q <= valid_i && (entry_q < ctrl_i.key);
      eq_q <= valid_i && (entry_q == ctrl_i.key);
    end
  end

  assign entry_o = entry_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

endmodule

// ===== hdl/ssid_check.sv =====
// Port-level checker for the sorted set engine, bound to the top level.
// Depends on ssid_pkg and sorted_set_insert_delete.
module ssid_check (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic                       found_i,
  input logic [ssid_pkg::CNT_W-1:0] position_i,
  input logic [ssid_pkg::CNT_W-1:0] count_i,
  input logic [1:0]                 status_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(position_i) && $stable(count_i))
    else $error("response word changed while stalled");

  a_dup_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ssid_pkg::ST_DUP) |-> found_i)
    else $error("duplicate status without found");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ssid_pkg::ST_FULL) |->
      !found_i && (count_i == ssid_pkg::CNT_W'(ssid_pkg::CAPACITY)))
    else $error("full status with a non-full set or a hit");

  a_missing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ssid_pkg::ST_MISSING) |-> !found_i)
    else $error("missing status with found set");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (position_i <= count_i))
    else $error("position beyond count");

endmodule

bind sorted_set_insert_delete ssid_check u_ssid_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .found_i     (rsp_o.found),
  .position_i  (rsp_o.position),
  .count_i     (rsp_o.count),
  .status_i    (rsp_o.status)
);

// ===== bench/sorted_set_insert_delete_tb.sv =====
// Testbench for sorted_set_insert_delete: random-stall driver and monitor on the
// request and response channels, checked against an in-bench model of the sorted set.
// Depends on ssid_pkg, ssid_req_if, ssid_rsp_if and the RTL top level.
module sorted_set_insert_delete_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_WORDS = 500;
  localparam int unsigned SETTLE_WAIT  = 16;
  localparam int unsigned POOL_SIZE    = 32;
  localparam int unsigned FULL_TRIES   = 20;

  typedef struct {
    ssid_pkg::op_e                     op;
    logic signed [ssid_pkg::KEY_W-1:0] key;
  } request_t;

  typedef struct packed {
    logic                       found;
    logic [ssid_pkg::CNT_W-1:0] position;
    logic [ssid_pkg::CNT_W-1:0] count;
    logic [1:0]                 status;
  } response_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ssid_req_if req_if ();
  ssid_rsp_if rsp_if ();

  sorted_set_insert_delete u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  request_t                          request_queue [$];
  response_t                         result_fifo [$];
  logic signed [ssid_pkg::KEY_W-1:0] planned_members [$];
  logic signed [ssid_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

  // Model of the stored set, advanced on every accepted request word.
  logic signed [ssid_pkg::KEY_W-1:0] set_vals [ssid_pkg::CAPACITY];
  int unsigned                       set_count = 0;

  int unsigned words_sent  = 0;
  int unsigned total_words = 1;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  function automatic response_t apply_request(logic [1:0] op,
                                              logic signed [ssid_pkg::KEY_W-1:0] k);
    response_t   r;
    int unsigned p;
    logic        hit;
    p = 0;
    while (p < set_count && set_vals[p] < k) p++;
    hit = (p < set_count) && (set_vals[p] == k);
    r.found    = hit;
    r.position = p[ssid_pkg::CNT_W-1:0];
    case (op)
      ssid_pkg::OP_INSERT: begin
        if (hit) begin
          r.status = ssid_pkg::ST_DUP;
        end else if (set_count >= ssid_pkg::CAPACITY) begin
          r.status = ssid_pkg::ST_FULL;
        end else begin
          for (int i = set_count; i > int'(p); i--) set_vals[i] = set_vals[i-1];
          set_vals[p] = k;
          set_count++;
          r.status = ssid_pkg::ST_DONE;
        end
      end
      ssid_pkg::OP_DELETE: begin
        if (hit) begin
          for (int i = p; i + 1 < int'(set_count); i++) set_vals[i] = set_vals[i+1];
          set_count--;
          r.status = ssid_pkg::ST_DONE;
        end else begin
          r.status = ssid_pkg::ST_MISSING;
        end
      end
      default: begin
        r.status = hit ? ssid_pkg::ST_DONE : ssid_pkg::ST_MISSING;
      end
    endcase
    r.count = set_count[ssid_pkg::CNT_W-1:0];
    return r;
  endfunction

  // 0: receiver sparse, 1: sender sparse, 2: both at full rate.
  function automatic int unsigned idle_phase();
    return (words_sent * 3) / total_words;
  endfunction

  // Queue a word and keep a rough picture of the set so that later words can aim at members.
  task automatic push_request(ssid_pkg::op_e op, logic signed [ssid_pkg::KEY_W-1:0] k);
    int idx [$];
    idx = planned_members.find_first_index() with (item == k);
    request_queue.push_back('{op: op, key: k});
    if (op == ssid_pkg::OP_INSERT && idx.size() == 0 &&
        planned_members.size() < ssid_pkg::CAPACITY)
      planned_members.push_back(k);
    if (op == ssid_pkg::OP_DELETE && idx.size() != 0)
      planned_members.delete(idx[0]);
  endtask

  function automatic logic signed [ssid_pkg::KEY_W-1:0] fresh_key();
    if ($urandom_range(0, 1) == 0) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom();
  endfunction

  function automatic logic signed [ssid_pkg::KEY_W-1:0] member_key();
    if (planned_members.size() == 0) return fresh_key();
    return planned_members[$urandom_range(0, planned_members.size() - 1)];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : p_drive
    request_t  nxt;
    response_t expected;
    int unsigned idle_pct;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      case (idle_phase())
        0:       idle_pct = 28;
        1:       idle_pct = 71;
        default: idle_pct = 0;
      endcase
      if (req_if.valid && req_if.ready) begin
        expected = apply_request(req_if.opcode, req_if.key_value);
        result_fifo.push_back(expected);
        words_sent <= words_sent + 1;
      end
      // Hold the word until it is taken; otherwise load the next one or idle.
      if (!req_if.valid || req_if.ready) begin
        if (request_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = request_queue.pop_front();
          req_if.valid     <= 1'b1;
          req_if.opcode    <= nxt.op;
          req_if.key_value <= nxt.key;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : p_monitor
    response_t got;
    response_t want;
    int unsigned idle_pct;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      case (idle_phase())
        0:       idle_pct = 71;
        1:       idle_pct = 28;
        default: idle_pct = 0;
      endcase
      rsp_if.ready <= ($urandom_range(0, 99) >= idle_pct);
      if (rsp_if.valid && rsp_if.ready) begin
        got = {rsp_if.found, rsp_if.position, rsp_if.count, rsp_if.status};
        if (result_fifo.size() == 0) begin
          $display("%0t: unexpected response word: found=%0d position=%0d count=%0d status=%0d",
                   $realtime, got.found, got.position, got.count, got.status);
          error_count++;
        end else begin
          want = result_fifo.pop_front();
          if (got !== want) begin
            $display("%0t: response mismatch: expected found=%0d position=%0d count=%0d status=%0d",
                     $realtime, want.found, want.position, want.count, want.status);
            $display("%0t:                    actual   found=%0d position=%0d count=%0d status=%0d",
                     $realtime, got.found, got.position, got.count, got.status);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned directed_n;
    int unsigned full_tries;
    int unsigned roll;
    bit          filling;

    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh8000_0001;
    key_pool[2] = 32'sh7FFF_FFFF;
    key_pool[3] = 32'sh7FFF_FFFE;
    key_pool[4] = 32'sd0;
    key_pool[5] = -32'sd1;
    key_pool[6] = 32'sd1;
    // Cluster the rest around zero so neighbors and repeats show up often.
    for (int i = 7; i < POOL_SIZE; i++)
      key_pool[i] = $signed(32'($urandom_range(0, 60))) - 32'sd30;

    // Directed: empty set, extremes, duplicate, lookups between entries, drain to empty.
    push_request(ssid_pkg::OP_LOOKUP, 32'sd0);
    push_request(ssid_pkg::OP_DELETE, 32'sd7);
    push_request(ssid_pkg::OP_INSERT, 32'sd0);
    push_request(ssid_pkg::OP_INSERT, 32'sh7FFF_FFFF);
    push_request(ssid_pkg::OP_INSERT, 32'sh8000_0000);
    push_request(ssid_pkg::OP_INSERT, -32'sd1);
    push_request(ssid_pkg::OP_INSERT, 32'sd1);
    push_request(ssid_pkg::OP_INSERT, 32'sd0);
    push_request(ssid_pkg::OP_LOOKUP, -32'sd1);
    push_request(ssid_pkg::OP_LOOKUP, 32'sd2);
    push_request(ssid_pkg::OP_LOOKUP, 32'sh7FFF_FFFF);
    push_request(ssid_pkg::OP_INSERT, 32'sh5555_5555);
    push_request(ssid_pkg::OP_INSERT, 32'shAAAA_AAAA);
    push_request(ssid_pkg::OP_DELETE, 32'sh7FFF_FFFF);
    push_request(ssid_pkg::OP_DELETE, 32'sh7FFF_FFFF);
    push_request(ssid_pkg::OP_DELETE, 32'sh8000_0000);
    push_request(ssid_pkg::OP_LOOKUP, 32'sh8000_0000);
    push_request(ssid_pkg::OP_DELETE, 32'sd0);
    push_request(ssid_pkg::OP_DELETE, -32'sd1);
    push_request(ssid_pkg::OP_DELETE, 32'sd1);
    push_request(ssid_pkg::OP_DELETE, 32'sh5555_5555);
    push_request(ssid_pkg::OP_DELETE, 32'shAAAA_AAAA);
    push_request(ssid_pkg::OP_LOOKUP, 32'shAAAA_AAAA);
    directed_n = request_queue.size();

    // Random: alternate filling the set to capacity (and pushing on it while full)
    // with draining it back to empty, with noise words mixed in.
    filling    = 1'b1;
    full_tries = 0;
    while (request_queue.size() < directed_n + RANDOM_WORDS) begin
      roll = $urandom_range(0, 99);
      if (filling) begin
        if (roll < 70)      push_request(ssid_pkg::OP_INSERT, fresh_key());
        else if (roll < 80) push_request(ssid_pkg::OP_INSERT, member_key());
        else if (roll < 86) push_request(ssid_pkg::OP_LOOKUP, member_key());
        else if (roll < 92) push_request(ssid_pkg::OP_LOOKUP, fresh_key());
        else if (roll < 96) push_request(ssid_pkg::OP_DELETE, fresh_key());
        else                push_request(ssid_pkg::OP_DELETE, member_key());
        if (planned_members.size() == ssid_pkg::CAPACITY) full_tries++;
        if (full_tries >= FULL_TRIES) filling = 1'b0;
      end else begin
        if (roll < 70)      push_request(ssid_pkg::OP_DELETE, member_key());
        else if (roll < 80) push_request(ssid_pkg::OP_DELETE, fresh_key());
        else if (roll < 92) push_request(ssid_pkg::OP_LOOKUP, member_key());
        else                push_request(ssid_pkg::OP_INSERT, fresh_key());
        if (planned_members.size() == 0) begin
          filling    = 1'b1;
          full_tries = 0;
        end
      end
    end
    total_words = request_queue.size();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(posedge clk_i);
    while (request_queue.size() != 0 || req_if.valid || result_fifo.size() != 0);
    repeat (SETTLE_WAIT) @(posedge clk_i);

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
